@@ src/ospd_pkg.sv @@
// shared types, constants and helpers of the sweep pulse disambiguator
package ospd_pkg;

    localparam int unsigned SENSOR_COUNT_DEF = 32;
    localparam int unsigned STORE_DEPTH      = 32;
    localparam int unsigned IDX_W            = 5;

    // register indexes
    localparam logic [2:0] REG_SYNC_MIN   = 3'd0;
    localparam logic [2:0] REG_MAX_VALID  = 3'd1;
    localparam logic [2:0] REG_SAME_GAP   = 3'd2;
    localparam logic [2:0] REG_SECOND_GAP = 3'd3;
    localparam logic [2:0] REG_CYCLE_GAP  = 3'd4;
    localparam logic [2:0] REG_WIN_LOW    = 3'd5;
    localparam logic [2:0] REG_WIN_HIGH   = 3'd6;

    localparam logic [15:0] SYNC_MIN_RST   = 16'd2500;
    localparam logic [15:0] MAX_VALID_RST  = 16'd6750;
    localparam logic [19:0] SAME_GAP_RST   = 20'd2400;
    localparam logic [19:0] SECOND_GAP_RST = 20'd24000;
    localparam logic [19:0] CYCLE_GAP_RST  = 20'd370000;
    localparam logic [19:0] WIN_LOW_RST    = 20'd70000;
    localparam logic [19:0] WIN_HIGH_RST   = 20'd380000;

    localparam logic KIND_HIT  = 1'b0;
    localparam logic KIND_SYNC = 1'b1;

    typedef struct packed {
        logic [7:0]  diode;
        logic [31:0] event_time;
        logic [15:0] pulse_length;
    } in_beat_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  sensor_index;
        logic [2:0]  code;
        logic [19:0] position;
        logic [31:0] report_time;
        logic [15:0] hit_length;
        logic        station;
        logic        last;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;       // capture the input beat
        logic sweep_update;  // apply a sweep hit
        logic scan_start;    // reset scan pointer, begin reading store
        logic scan_step;     // read the next store entry
        logic sync_apply;    // update station state after the flush
        logic stn_start;     // reset station pointer
        logic stn_step;      // consider current station
        logic out_take;      // load the hold register from candidate
        logic out_push;      // move the hold register to the output
        logic mark_last;     // the pushed beat is the final one
    } ospd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic drop;          // bad sensor or overlong
        logic is_sync;
        logic new_cycle;     // gap above the new cycle bound
        logic cand_valid;    // current scan or station entry is reportable
        logic scan_done;     // pointer is on the last store entry
        logic stn_done;      // pointer is on the last station
    } ospd_sts_t;

    // 3-bit sync code from length thresholds
    function automatic logic [2:0] code_of(input logic [15:0] len);
        logic [2:0] c;
        c = 3'd0;
        if (len >= 16'd3250) c = 3'd1;
        if (len >= 16'd3750) c = 3'd2;
        if (len >= 16'd4250) c = 3'd3;
        if (len >= 16'd4750) c = 3'd4;
        if (len >= 16'd5250) c = 3'd5;
        if (len >= 16'd5750) c = 3'd6;
        if (len >= 16'd6250) c = 3'd7;
        return c;
    endfunction

endpackage

@@ src/ospd_datapath.sv @@
// datapath: registers, hit store, station state and output register
module ospd_datapath #(
    parameter int unsigned SENSOR_COUNT = ospd_pkg::SENSOR_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_en,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    input  ospd_pkg::in_beat_t  in_beat,
    input  ospd_pkg::ospd_cmd_t cmd,
    output ospd_pkg::ospd_sts_t sts,
    output ospd_pkg::out_beat_t out_beat
);
    import ospd_pkg::*;

    logic [15:0] sync_min_reg, max_valid_reg;
    logic [19:0] same_gap_reg, second_gap_reg, cycle_gap_reg, win_low_reg, win_high_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_min_reg   <= SYNC_MIN_RST;
            max_valid_reg  <= MAX_VALID_RST;
            same_gap_reg   <= SAME_GAP_RST;
            second_gap_reg <= SECOND_GAP_RST;
            cycle_gap_reg  <= CYCLE_GAP_RST;
            win_low_reg    <= WIN_LOW_RST;
            win_high_reg   <= WIN_HIGH_RST;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_SYNC_MIN:   sync_min_reg   <= cfg_data[15:0];
                REG_MAX_VALID:  max_valid_reg  <= cfg_data[15:0];
                REG_SAME_GAP:   same_gap_reg   <= cfg_data;
                REG_SECOND_GAP: second_gap_reg <= cfg_data;
                REG_CYCLE_GAP:  cycle_gap_reg  <= cfg_data;
                REG_WIN_LOW:    win_low_reg    <= cfg_data;
                REG_WIN_HIGH:   win_high_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured input beat
    in_beat_t in_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load_in) in_reg <= in_beat;
    end

    // station state
    logic        valid_reg [STORE_DEPTH];
    logic [31:0] last_sync_reg;
    logic [31:0] stn_time_reg [2];
    logic [15:0] stn_len_reg [2];
    logic [3:0]  stn_code_reg [2];
    logic        cur_stn_reg;
    logic        act_none_reg;
    logic        act_stn_reg;
    logic [31:0] act_time_reg;
    logic [2:0]  act_code_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic        sptr_reg;

    // hit store memory; entry validity is kept in separate valid bits
    logic [15:0] mem_len [STORE_DEPTH];
    logic [31:0] mem_time [STORE_DEPTH];
    logic [15:0] rd_len;
    logic [31:0] rd_time;
    logic        rd_valid;
    logic [15:0] cur_len_reg;   // stored length of the captured sensor

    logic [IDX_W-1:0] sid_idx;
    assign sid_idx = in_reg.diode[IDX_W-1:0];

    // decode of the captured pulse
    logic drop, is_sync;
    logic [2:0] in_code;
    logic [31:0] gap;
    logic gap_same, gap_second, gap_cycle;
    assign drop = (in_reg.diode >= 8'(SENSOR_COUNT)) || (in_reg.pulse_length > max_valid_reg);
    assign is_sync = in_reg.pulse_length >= sync_min_reg;
    assign in_code = code_of(in_reg.pulse_length);
    assign gap = in_reg.event_time - last_sync_reg;
    assign gap_same = $signed(gap) < $signed({12'd0, same_gap_reg});
    assign gap_second = $signed(gap) < $signed({12'd0, second_gap_reg});
    assign gap_cycle = $signed(gap) > $signed({12'd0, cycle_gap_reg});

    // active station selection, last eligible wins
    logic sel_none, sel_stn;
    always_comb
    begin
        sel_none = 1'b1;
        sel_stn  = 1'b0;
        if (!stn_code_reg[0][3] && !stn_code_reg[0][2])
        begin
            sel_none = 1'b0;
            sel_stn  = 1'b0;
        end
        if (!stn_code_reg[1][3] && !stn_code_reg[1][2])
        begin
            sel_none = 1'b0;
            sel_stn  = 1'b1;
        end
    end

    // sweep offset of the registered store entry
    logic [31:0] off;
    logic hit_ok;
    assign off = rd_time - act_time_reg + {17'd0, rd_len[15:1]};
    assign hit_ok = rd_valid && !off[31] && (off > {12'd0, win_low_reg})
                    && (off < {12'd0, win_high_reg});

    // station report candidate
    logic stn_ok;
    assign stn_ok = stn_len_reg[sptr_reg] != 16'd0;

    logic stn_mode_reg;

    assign sts.drop       = drop;
    assign sts.is_sync    = is_sync;
    assign sts.new_cycle  = !gap_same && !gap_second && gap_cycle;
    assign sts.cand_valid = stn_mode_reg ? stn_ok : hit_ok;
    assign sts.scan_done  = ptr_reg == IDX_W'(STORE_DEPTH - 1);
    assign sts.stn_done   = sptr_reg;

    // a zero length never beats an empty entry
    logic sweep_wr;
    assign sweep_wr = cmd.sweep_update && !sel_none && (in_reg.pulse_length != 16'd0)
                      && (!valid_reg[sid_idx] || cur_len_reg < in_reg.pulse_length);

    // memory write and registered reads
    always_ff @(posedge clk)
    begin
        if (sweep_wr)
        begin
            mem_len[sid_idx]  <= in_reg.pulse_length;
            mem_time[sid_idx] <= in_reg.event_time;
        end
        if (cmd.load_in) cur_len_reg <= mem_len[in_beat.diode[IDX_W-1:0]];
        if (cmd.scan_step)
        begin
            rd_len  <= mem_len[ptr_reg];
            rd_time <= mem_time[ptr_reg];
        end
    end

    // state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++) valid_reg[i] <= 1'b0;
            last_sync_reg <= '0;
            for (int s = 0; s < 2; s++)
            begin
                stn_time_reg[s] <= '0;
                stn_len_reg[s]  <= '0;
                stn_code_reg[s] <= '0;
            end
            cur_stn_reg  <= 1'b0;
            act_none_reg <= 1'b0;
            act_stn_reg  <= 1'b0;
            act_time_reg <= '0;
            act_code_reg <= '0;
            ptr_reg      <= '0;
            sptr_reg     <= 1'b0;
            rd_valid     <= 1'b0;
            stn_mode_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_update)
            begin
                act_none_reg <= sel_none;
                act_stn_reg  <= sel_stn;
                act_time_reg <= sel_none ? 32'd0 : stn_time_reg[sel_stn];
                act_code_reg <= sel_none ? 3'd0 : stn_code_reg[sel_stn][2:0];
                if (sweep_wr) valid_reg[sid_idx] <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                ptr_reg      <= '0;
                stn_mode_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                // valid of the entry read alongside the memory
                ptr_reg  <= ptr_reg + 1'b1;
                rd_valid <= valid_reg[ptr_reg];
            end
            if (cmd.sync_apply)
            begin
                for (int i = 0; i < STORE_DEPTH; i++) valid_reg[i] <= 1'b0;
                if (gap_same)
                begin
                    last_sync_reg <= in_reg.event_time;
                    if (in_reg.pulse_length > stn_len_reg[cur_stn_reg])
                    begin
                        stn_len_reg[cur_stn_reg]  <= in_reg.pulse_length;
                        stn_time_reg[cur_stn_reg] <= in_reg.event_time;
                        stn_code_reg[cur_stn_reg] <= {1'b0, in_code};
                    end
                end
                else if (gap_second)
                begin
                    last_sync_reg   <= in_reg.event_time;
                    cur_stn_reg     <= 1'b1;
                    stn_time_reg[1] <= in_reg.event_time;
                    stn_len_reg[1]  <= in_reg.pulse_length;
                    stn_code_reg[1] <= {1'b0, in_code};
                end
                else if (gap_cycle)
                begin
                    stn_time_reg[1] <= '0;
                    stn_len_reg[1]  <= '0;
                    stn_code_reg[1] <= 4'hF;
                    act_none_reg    <= 1'b1;
                    act_stn_reg     <= 1'b0;
                    act_time_reg    <= '0;
                    act_code_reg    <= '0;
                    last_sync_reg   <= in_reg.event_time;
                    cur_stn_reg     <= 1'b0;
                    stn_time_reg[0] <= in_reg.event_time;
                    stn_len_reg[0]  <= in_reg.pulse_length;
                    stn_code_reg[0] <= {1'b0, in_code};
                end
            end
            if (cmd.stn_start)
            begin
                sptr_reg     <= 1'b0;
                stn_mode_reg <= 1'b1;
            end
            else if (cmd.stn_step)
            begin
                sptr_reg <= 1'b1;
            end
        end
    end

    // hold register for the newest report, output register for the shown beat
    out_beat_t hold_reg;
    logic [4:0] hit_idx;
    assign hit_idx = ptr_reg - 1'b1;
    always_ff @(posedge clk)
    begin
        if (cmd.out_take)
        begin
            if (stn_mode_reg)
            begin
                hold_reg.kind         <= KIND_SYNC;
                hold_reg.sensor_index <= '0;
                hold_reg.code         <= code_of(stn_len_reg[sptr_reg]);
                hold_reg.position     <= {4'd0, stn_len_reg[sptr_reg]};
                hold_reg.report_time  <= stn_time_reg[sptr_reg];
                hold_reg.hit_length   <= '0;
                hold_reg.station      <= sptr_reg;
            end
            else
            begin
                hold_reg.kind         <= KIND_HIT;
                hold_reg.sensor_index <= hit_idx;
                hold_reg.code         <= act_code_reg;
                hold_reg.position     <= off[19:0];
                hold_reg.report_time  <= rd_time;
                hold_reg.hit_length   <= rd_len;
                hold_reg.station      <= act_none_reg ? 1'b1 : act_stn_reg;
            end
            hold_reg.last <= 1'b0;
        end
        if (cmd.out_push)
        begin
            out_beat <= {hold_reg[$bits(out_beat_t)-1:1], cmd.mark_last};
        end
    end

endmodule

@@ src/ospd_ctrl.sv @@
// controller: sequences decode, store flush, station reports and output
module ospd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  ospd_pkg::ospd_sts_t sts,
    output ospd_pkg::ospd_cmd_t cmd
);
    import ospd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_PRIME  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_APPLY  = 3'd4;
    localparam logic [2:0] S_STN    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       held_reg, held_next;       // hold register has a beat not yet shown
    logic       ovalid_reg, ovalid_next;
    logic       cycle_reg, cycle_next;     // this sync starts a new cycle
    logic       scan_end_reg, scan_end_next;

    logic out_free;
    assign out_free = !ovalid_reg || !out_stall;

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        ovalid_next   = ovalid_reg && out_stall;
        cycle_next    = cycle_reg;
        scan_end_next = scan_end_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.drop)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.is_sync)
                begin
                    cmd.sweep_update = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cycle_next     = sts.new_cycle;
                    held_next      = 1'b0;
                    scan_end_next  = 1'b0;
                    state_next     = S_PRIME;
                end
            end
            S_PRIME:
            begin
                // first read of the store lands next cycle
                cmd.scan_step = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                // registered entry is ptr-1; a found hit waits for a free output while a report is held
                if (!sts.cand_valid || (!held_reg || out_free))
                begin
                    if (sts.cand_valid)
                    begin
                        if (held_reg)
                        begin
                            ovalid_next  = 1'b1;
                            cmd.out_push = 1'b1;
                        end
                        cmd.out_take = 1'b1;
                        held_next    = 1'b1;
                    end
                    if (scan_end_reg)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        // the read of the last entry wraps the pointer
                        if (sts.scan_done) scan_end_next = 1'b1;
                        cmd.scan_step = 1'b1;
                    end
                end
            end
            S_APPLY:
            begin
                cmd.stn_start = cycle_reg;
                if (!cycle_reg || !held_reg || out_free)
                begin
                    if (!cycle_reg) state_next = S_FINISH;
                    else state_next = S_STN;
                end
                else
                begin
                    cmd.stn_start = 1'b0;
                end
                if (state_next != S_APPLY) cmd.sync_apply = !cycle_reg;
            end
            S_STN:
            begin
                if (!sts.cand_valid || !held_reg || out_free)
                begin
                    if (sts.cand_valid)
                    begin
                        if (held_reg)
                        begin
                            ovalid_next  = 1'b1;
                            cmd.out_push = 1'b1;
                        end
                        cmd.out_take = 1'b1;
                        held_next    = 1'b1;
                    end
                    if (sts.stn_done)
                    begin
                        cmd.sync_apply = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        cmd.stn_step = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (!held_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    cmd.out_push  = 1'b1;
                    cmd.mark_last = 1'b1;
                    ovalid_next   = 1'b1;
                    held_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
            cycle_reg    <= 1'b0;
            scan_end_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            ovalid_reg   <= ovalid_next;
            cycle_reg    <= cycle_next;
            scan_end_reg <= scan_end_next;
        end
    end

endmodule

@@ src/optical_sweep_pulse_disambiguator.sv @@
// top level of the optical sweep pulse disambiguator
//
//   channel  direction  handshake          payload
//   in       into block in_valid/in_stall  in_beat (sensor, time, length)
//   out      from block out_valid/out_stall out_beat (one report)
//   cfg      into block cfg_en             cfg_index, cfg_data
//
// a sweep pulse or dropped pulse is decoded and the block returns to idle; a sync
// also scans the 32-entry store, one memory read per cycle while no waiting report
// is stalled, and on a new cycle also reports the two station slots
// reset clears the hit store valid bits at once; no clearing pass
// the newest report waits in a hold register so the final one can be flagged;
// a stalled output holds the block once a second report is waiting
module optical_sweep_pulse_disambiguator #(
    parameter int unsigned SENSOR_COUNT = ospd_pkg::SENSOR_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ospd_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output ospd_pkg::out_beat_t out_beat,
    input  logic                cfg_en,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data
);
    import ospd_pkg::*;

    ospd_cmd_t cmd;
    ospd_sts_t sts;

    ospd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ospd_datapath #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .cmd       (cmd),
        .sts       (sts),
        .out_beat  (out_beat)
    );

endmodule

@@ verif/ospd_checker.sv @@
// report predictor and scoreboard for the sweep pulse disambiguator
`timescale 1ns / 100ps

module ospd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  ospd_pkg::in_beat_t  in_beat,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ospd_pkg::out_beat_t out_beat,
    input  logic                cfg_en,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    output int                  error_count,
    output int                  reports_pending
);
    import ospd_pkg::*;

    // register copies
    logic [15:0] sync_min, max_valid;
    logic [19:0] same_gap, second_gap, cycle_gap, win_low, win_high;

    // pulse history copies
    logic [15:0] hit_len [STORE_DEPTH];
    logic [31:0] hit_time [STORE_DEPTH];
    logic [31:0] last_sync;
    logic [31:0] stn_start [2];
    logic [15:0] stn_max [2];
    int          stn_code [2];
    logic        cur_stn;
    int          act_stn;
    logic [31:0] act_start;
    logic [2:0]  act_code;

    out_beat_t expected_reports [$];

    // sync code ladder
    function automatic logic [2:0] sync_code(input logic [15:0] len);
        int unsigned bounds [7] = '{3250, 3750, 4250, 4750, 5250, 5750, 6250};
        logic [2:0] c;
        c = 3'd0;
        for (int k = 0; k < 7; k++)
            if (len >= bounds[k]) c = 3'(k + 1);
        return c;
    endfunction

    // reports caused by one accepted pulse
    task automatic predict_pulse(input in_beat_t b);
        out_beat_t   rep;
        out_beat_t   reps [$];
        logic [31:0] off;
        logic [31:0] d;
        longint      gap;
        logic [2:0]  code;
        if (b.diode >= SENSOR_COUNT_DEF) return;
        if (b.pulse_length > max_valid) return;
        if (b.pulse_length >= sync_min) begin
            code = sync_code(b.pulse_length);
            // flush stored sweep hits inside the window
            for (int i = 0; i < STORE_DEPTH; i++) begin
                if (hit_len[i] != 0) begin
                    off = hit_time[i] - act_start + 32'(hit_len[i] / 2);
                    if (!off[31] && off > 32'(win_low) && off < 32'(win_high)) begin
                        rep = '0;
                        rep.kind = KIND_HIT;
                        rep.sensor_index = 5'(i);
                        rep.code = act_code;
                        rep.position = off[19:0];
                        rep.report_time = hit_time[i];
                        rep.hit_length = hit_len[i];
                        rep.station = act_stn[0];
                        reps.push_back(rep);
                    end
                end
                hit_len[i] = '0;
                hit_time[i] = '0;
            end
            d = b.event_time - last_sync;
            gap = longint'($signed(d));
            if (gap < longint'(same_gap)) begin
                last_sync = b.event_time;
                if (b.pulse_length > stn_max[cur_stn]) begin
                    stn_max[cur_stn] = b.pulse_length;
                    stn_start[cur_stn] = b.event_time;
                    stn_code[cur_stn] = int'(code);
                end
            end else if (gap < longint'(second_gap)) begin
                last_sync = b.event_time;
                cur_stn = 1'b1;
                stn_start[1] = b.event_time;
                stn_max[1] = b.pulse_length;
                stn_code[1] = int'(code);
            end else if (gap > longint'(cycle_gap)) begin
                // new cycle first reports every station with a nonzero length
                for (int s = 0; s < 2; s++) begin
                    if (stn_max[s] != 0) begin
                        rep = '0;
                        rep.kind = KIND_SYNC;
                        rep.code = sync_code(stn_max[s]);
                        rep.position = 20'(stn_max[s]);
                        rep.report_time = stn_start[s];
                        rep.station = 1'(s);
                        reps.push_back(rep);
                    end
                    stn_start[s] = '0;
                    stn_max[s] = '0;
                    stn_code[s] = -1;
                end
                act_stn = -1;
                act_start = '0;
                act_code = '0;
                last_sync = b.event_time;
                cur_stn = 1'b0;
                stn_start[0] = b.event_time;
                stn_max[0] = b.pulse_length;
                stn_code[0] = int'(code);
            end
            if (reps.size() > 0) reps[reps.size() - 1].last = 1'b1;
            foreach (reps[k]) expected_reports.push_back(reps[k]);
            return;
        end
        // sweep hit: pick the active station, keep the longest hit
        act_stn = -1;
        act_start = '0;
        act_code = '0;
        for (int s = 0; s < 2; s++) begin
            if (stn_code[s] >= 0 && stn_code[s][2] == 1'b0) begin
                act_stn = s;
                act_start = stn_start[s];
                act_code = stn_code[s][2:0];
            end
        end
        if (act_stn < 0) return;
        if (hit_len[b.diode] < b.pulse_length) begin
            hit_len[b.diode] = b.pulse_length;
            hit_time[b.diode] = b.event_time;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_beat_t want;
        if (!rst_n) begin
            sync_min = SYNC_MIN_RST;
            max_valid = MAX_VALID_RST;
            same_gap = SAME_GAP_RST;
            second_gap = SECOND_GAP_RST;
            cycle_gap = CYCLE_GAP_RST;
            win_low = WIN_LOW_RST;
            win_high = WIN_HIGH_RST;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                hit_len[i] = '0;
                hit_time[i] = '0;
            end
            last_sync = '0;
            stn_start = '{default: '0};
            stn_max = '{default: '0};
            stn_code = '{default: 0};
            cur_stn = 1'b0;
            act_stn = 0;
            act_start = '0;
            act_code = '0;
            expected_reports.delete();
            error_count = 0;
            reports_pending = 0;
        end else begin
            // register writes
            if (cfg_en) begin
                case (cfg_index)
                    REG_SYNC_MIN:   sync_min = cfg_data[15:0];
                    REG_MAX_VALID:  max_valid = cfg_data[15:0];
                    REG_SAME_GAP:   same_gap = cfg_data;
                    REG_SECOND_GAP: second_gap = cfg_data;
                    REG_CYCLE_GAP:  cycle_gap = cfg_data;
                    REG_WIN_LOW:    win_low = cfg_data;
                    REG_WIN_HIGH:   win_high = cfg_data;
                    default: ;
                endcase
            end
            // input beat
            if (in_valid && !in_stall) predict_pulse(in_beat);
            // output beat
            if (out_valid && !out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report beat %h", out_beat);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("kind", 32'(want.kind), 32'(out_beat.kind));
                    check_field("sensor_index", 32'(want.sensor_index),
                                32'(out_beat.sensor_index));
                    check_field("code", 32'(want.code), 32'(out_beat.code));
                    check_field("position", 32'(want.position), 32'(out_beat.position));
                    check_field("report_time", want.report_time, out_beat.report_time);
                    check_field("hit_length", 32'(want.hit_length),
                                32'(out_beat.hit_length));
                    check_field("station", 32'(want.station), 32'(out_beat.station));
                    check_field("last", 32'(want.last), 32'(out_beat.last));
                end
            end
            reports_pending = expected_reports.size();
        end
    end

endmodule

@@ verif/optical_sweep_pulse_disambiguator_tb.sv @@
// stimulus and verdict for the sweep pulse disambiguator
`timescale 1ns / 100ps

module optical_sweep_pulse_disambiguator_tb;
    import ospd_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    // an index past the register list
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_beat_t    in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_beat_t   out_beat;
    logic        cfg_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;
    int          error_count;
    int          reports_pending;

    // register values currently written
    logic [15:0] c_sync_min, c_max_valid;
    logic [19:0] c_same, c_second, c_cycle, c_wlo, c_whi;
    logic [31:0] sync_clock;
    int          beats_out = 0;
    int          stall_left = 0;
    bit          calm_send = 0;
    int          idle_cycles = 0;

    optical_sweep_pulse_disambiguator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
        .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ospd_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
        .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .reports_pending(reports_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver stall: random per beat, calm stretches, one long hold-off
    always @(posedge clk)
    begin
        if (out_valid && !out_stall) begin
            beats_out <= beats_out + 1;
            if (beats_out == 40)
                stall_left <= 400;
            else if ((beats_out / 50) % 3 == 2)
                stall_left <= 0;
            else
                stall_left <= $urandom_range(0, 3);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(negedge clk)
        out_stall = (stall_left > 0);

    // watchdog on beats in either direction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // offer one pulse and hold it until taken, then an optional gap
    task automatic send_pulse(input logic [7:0] sid, input logic [31:0] t,
                              input logic [15:0] len);
        int gap;
        @(negedge clk);
        in_valid = 1'b1;
        in_beat.diode = sid;
        in_beat.event_time = t;
        in_beat.pulse_length = len;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        gap = calm_send ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(negedge clk);
        in_valid = 1'b0;
        cfg_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_en = 1'b0;
    endtask

    // wait for every report, then let the block settle
    task automatic drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (reports_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all registers; 16-bit ones get random upper data bits
    task automatic load_regs(input logic [15:0] smin, input logic [15:0] mval,
                             input logic [19:0] same, input logic [19:0] second,
                             input logic [19:0] cyc, input logic [19:0] wlo,
                             input logic [19:0] whi);
        drain();
        write_reg(REG_SYNC_MIN, {4'($urandom), smin});
        write_reg(REG_MAX_VALID, {4'($urandom), mval});
        write_reg(REG_SAME_GAP, same);
        write_reg(REG_SECOND_GAP, second);
        write_reg(REG_CYCLE_GAP, cyc);
        write_reg(REG_WIN_LOW, wlo);
        write_reg(REG_WIN_HIGH, whi);
        write_reg(REG_UNUSED, 20'($urandom));
        c_sync_min = smin;
        c_max_valid = mval;
        c_same = same;
        c_second = second;
        c_cycle = cyc;
        c_wlo = wlo;
        c_whi = whi;
    endtask

    function automatic logic [15:0] sync_len();
        int unsigned hi;
        if (c_sync_min > c_max_valid) return c_sync_min;
        hi = c_max_valid;
        // mostly codes with bit 2 clear so a station becomes active
        if ($urandom_range(0, 9) < 7 && c_sync_min < 4750 && hi > 4749) hi = 4749;
        return 16'($urandom_range(c_sync_min, hi));
    endfunction

    function automatic logic [15:0] short_len();
        int unsigned hi;
        hi = (c_sync_min == 0) ? 0 : c_sync_min - 1;
        if (hi > c_max_valid) hi = c_max_valid;
        return 16'($urandom_range((hi == 0) ? 0 : 1, hi));
    endfunction

    function automatic logic [7:0] pick_sensor();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(32, 255))
                                           : 8'($urandom_range(0, 31));
    endfunction

    // sweep hits centred around the window of a station start
    task automatic sweep_burst(input logic [31:0] start);
        logic [15:0] len;
        logic [31:0] centre;
        repeat ($urandom_range(2, 10)) begin
            len = short_len();
            centre = start + $urandom_range(c_wlo, c_whi + 20'd2000) - 32'd1000;
            send_pulse(pick_sensor(), centre - 32'(len / 2), len);
        end
    endtask

    // one sync cycle: new cycle burst, sweeps, second station, sweeps, late sync; or one random pulse
    task automatic sync_cycle(inout int sent);
        logic [31:0] start;
        if ($urandom_range(0, 6) == 0) begin
            send_pulse(8'($urandom), $urandom, 16'($urandom));
            sent++;
            return;
        end
        sync_clock = sync_clock + c_cycle + $urandom_range(1, 50000);
        send_pulse(pick_sensor(), sync_clock, sync_len());
        sent++;
        start = sync_clock;
        repeat ($urandom_range(0, 2)) begin
            if (c_same > 0) sync_clock = sync_clock + $urandom_range(0, c_same - 1);
            send_pulse(8'($urandom_range(0, 31)), sync_clock, sync_len());
            sent++;
        end
        sweep_burst(start);
        sent += 6;
        if (c_second > c_same && $urandom_range(0, 3) != 0) begin
            sync_clock = sync_clock + $urandom_range(c_same, c_second - 1);
            send_pulse(8'($urandom_range(0, 31)), sync_clock, sync_len());
            sent++;
            sweep_burst(sync_clock);
            sent += 6;
        end
        if (c_cycle > c_second && $urandom_range(0, 4) == 0) begin
            sync_clock = sync_clock + $urandom_range(c_second, c_cycle);
            send_pulse(8'($urandom_range(0, 31)), sync_clock, sync_len());
            sent++;
        end
    endtask

    task automatic random_phase(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            calm_send = ($urandom_range(0, 4) == 0);
            sync_cycle(sent);
        end
        calm_send = 0;
    endtask

    initial
    begin
        logic [15:0] smin;
        logic [19:0] same, second, wlo;
        c_sync_min = SYNC_MIN_RST;
        c_max_valid = MAX_VALID_RST;
        c_same = SAME_GAP_RST;
        c_second = SECOND_GAP_RST;
        c_cycle = CYCLE_GAP_RST;
        c_wlo = WIN_LOW_RST;
        c_whi = WIN_HIGH_RST;
        sync_clock = $urandom;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: drops, bursts, stations, windows, sign cases
        send_pulse(8'd32, 32'd100, 16'd100);
        send_pulse(8'd255, 32'd400000, 16'd3000);
        send_pulse(8'd3, 32'd400000, 16'd6751);
        send_pulse(8'd3, 32'hFFFFFFFF, 16'hFFFF);
        send_pulse(8'd0, 32'd50, 16'd200);
        send_pulse(8'd0, 32'd400000, 16'd2500);
        send_pulse(8'd1, 32'd401000, 16'd3000);
        send_pulse(8'd0, 32'd500000, 16'd100);
        send_pulse(8'd31, 32'd700000, 16'd2499);
        send_pulse(8'd31, 32'd710000, 16'd50);
        send_pulse(8'd5, 32'd300000, 16'd1000);
        send_pulse(8'd6, 32'd402000, 16'd0);
        send_pulse(8'd2, 32'd390000, 16'd6750);
        send_pulse(8'd2, 32'd405000, 16'd3300);
        send_pulse(8'd7, 32'd480000, 16'd1);
        send_pulse(8'd2, 32'd600000, 16'd4000);
        send_pulse(8'd9, 32'd1100000, 16'd6250);
        send_pulse(8'd10, 32'd1200000, 16'd300);
        send_pulse(8'd4, 32'd1110000, 16'd5000);
        send_pulse(8'd11, 32'd1300000, 16'd300);
        send_pulse(8'd1, 32'hFFFF0000, 16'd3749);
        send_pulse(8'd1, 32'h00010000, 16'd4749);
        send_pulse(8'd12, 32'h00020000, 16'd2000);
        send_pulse(8'd1, 32'h00090000, 16'd2600);

        random_phase(100);

        // random moderate settings
        smin = 16'($urandom_range(1500, 3500));
        same = 20'($urandom_range(500, 3000));
        second = same + 20'($urandom_range(5000, 30000));
        wlo = 20'($urandom_range(0, 80000));
        load_regs(smin, smin + 16'($urandom_range(1000, 4000)), same, second,
                  second + 20'($urandom_range(100000, 400000)), wlo,
                  wlo + 20'($urandom_range(100000, 600000)));
        random_phase(70);

        // all ones
        load_regs(16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                  20'hFFFFF, 20'hFFFFF);
        random_phase(15);
        send_pulse(8'd3, 32'h80000000, 16'hFFFF);

        // all zeros
        load_regs(16'd0, 16'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        random_phase(15);

        // wide window, back to reset-like gaps
        load_regs(SYNC_MIN_RST, MAX_VALID_RST, SAME_GAP_RST, SECOND_GAP_RST,
                  CYCLE_GAP_RST, 20'd1, 20'd500000);
        random_phase(50);

        drain();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ optical_sweep_pulse_disambiguator.f @@
src/ospd_pkg.sv
src/ospd_datapath.sv
src/ospd_ctrl.sv
src/optical_sweep_pulse_disambiguator.sv
verif/ospd_checker.sv
verif/optical_sweep_pulse_disambiguator_tb.sv
